>>> rtl/core/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg: shared types and constants of the sorted name record table
// Table sizes, field widths, command and status codes, the stored entry layout
// and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package srt_pkg;

   localparam int CAPACITY      = 64;
   localparam int NAME_BYTES    = 8;
   localparam int NAME_BITS     = NAME_BYTES * 8;
   localparam int FIELD_W       = 64;
   localparam int ADDR_W        = $clog2(CAPACITY);
   localparam int COUNT_W       = $clog2(CAPACITY + 1);
   localparam int INDEX_W       = 6;
   localparam int IDX_CMP_W     = (COUNT_W > INDEX_W) ? COUNT_W : INDEX_W;
   localparam int OP_W          = 3;
   localparam int STATUS_W      = 2;
   localparam int ENTRY_COUNT_W = 7;

   localparam logic [OP_W-1:0] OP_INSERT = OP_W'(0);
   localparam logic [OP_W-1:0] OP_DELETE = OP_W'(1);
   localparam logic [OP_W-1:0] OP_FIND   = OP_W'(2);
   localparam logic [OP_W-1:0] OP_CLEAR  = OP_W'(3);
   localparam logic [OP_W-1:0] OP_READ   = OP_W'(4);

   localparam logic [STATUS_W-1:0] ST_OK        = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] ST_FULL      = STATUS_W'(2);
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX = STATUS_W'(3);

   typedef struct packed {
      logic [NAME_BITS-1:0] number;
      logic [NAME_BITS-1:0] last;
      logic [NAME_BITS-1:0] first;
   } entry_type;

   typedef enum logic [10:0] {
      S_IDLE      = 11'b000_0000_0001,
      S_INS_RD    = 11'b000_0000_0010,
      S_INS_CMP   = 11'b000_0000_0100,
      S_INS_PUT   = 11'b000_0000_1000,
      S_SCAN_RD   = 11'b000_0001_0000,
      S_SCAN_CMP  = 11'b000_0010_0000,
      S_SHIFT_RD  = 11'b000_0100_0000,
      S_SHIFT_WR  = 11'b000_1000_0000,
      S_READ_RD   = 11'b001_0000_0000,
      S_READ_DATA = 11'b010_0000_0000,
      S_DONE      = 11'b100_0000_0000
   } state_type;

endpackage

`default_nettype wire

>>> rtl/core/sorted_name_record_table.sv
// ----------------------------------------------------------------------------
// sorted_name_record_table: table of name records kept sorted by first name
// Insert, delete, find, clear and read by index over one entry RAM.
//
// Usage:
//   The req_ channel carries one command item; the rsp_ channel returns one
//   result item per command. Both use valid/stall; an item moves on an edge
//   with valid high and stall low. req_stall is high while a command runs.
//   The sequencer walks the entry RAM one entry at a time and then posts the
//   result. What each command does:
//     clear, unknown op, full table : result posted with no RAM pass
//     read                          : one read of the indexed entry
//     insert                        : entries above the new one move up a place
//     find                          : scan from entry 0 up to the hit or the end
//     delete                        : find, then entries above the hit move down
//   One command is in work at a time. The result sits in an output
//   register, so the next command is taken while rsp_stall holds the
//   previous result; a finished command waits for that register to free.
//   Reset empties the table at once (no clearing pass) and drops any
//   pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_name_record_table (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [srt_pkg::OP_W-1:0]             req_op,
   input  wire logic [srt_pkg::FIELD_W-1:0]          req_first_name,
   input  wire logic [srt_pkg::FIELD_W-1:0]          req_last_name,
   input  wire logic [srt_pkg::FIELD_W-1:0]          req_phone_number,
   input  wire logic [srt_pkg::INDEX_W-1:0]          req_entry_index,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [srt_pkg::STATUS_W-1:0]              rsp_status,
   output logic [srt_pkg::FIELD_W-1:0]               rsp_found_first,
   output logic [srt_pkg::FIELD_W-1:0]               rsp_found_last,
   output logic [srt_pkg::FIELD_W-1:0]               rsp_found_number,
   output logic [srt_pkg::ENTRY_COUNT_W-1:0]         rsp_entry_count
);

   import srt_pkg::*;

   state_type                state_ff, state_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [COUNT_W-1:0]       k_ff, k_in;
   logic [OP_W-1:0]          op_ff, op_in;
   logic [NAME_BITS-1:0]     first_ff, first_in;
   logic [NAME_BITS-1:0]     last_ff, last_in;
   logic [NAME_BITS-1:0]     number_ff, number_in;
   logic [STATUS_W-1:0]      res_status_ff, res_status_in;
   entry_type                res_entry_ff, res_entry_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [FIELD_W-1:0]       rsp_first_ff, rsp_first_in;
   logic [FIELD_W-1:0]       rsp_last_ff, rsp_last_in;
   logic [FIELD_W-1:0]       rsp_number_ff, rsp_number_in;
   logic [ENTRY_COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                     ram_wr_en;
   logic [ADDR_W-1:0]        ram_wr_addr;
   entry_type                ram_wr_data;
   logic [ADDR_W-1:0]        ram_rd_addr;
   entry_type                ram_rd_data;

   logic                     rsp_free;
   entry_type                new_entry;
   logic [COUNT_W-1:0]       k_dec, k_inc, k_inc2;
   logic                     hit;

   srt_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(CAPACITY)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign new_entry = '{number: number_ff, last: last_ff, first: first_ff};
   assign k_dec     = k_ff - COUNT_W'(1);
   assign k_inc     = k_ff + COUNT_W'(1);
   assign k_inc2    = k_ff + COUNT_W'(2);
   assign hit       = (ram_rd_data.first == first_ff) && (ram_rd_data.last == last_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      k_in          = k_ff;
      op_in         = op_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      number_in     = number_ff;
      res_status_in = res_status_ff;
      res_entry_in  = res_entry_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_number_in = rsp_number_ff;
      rsp_count_in  = rsp_count_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = k_ff[ADDR_W-1:0];
      ram_wr_data   = ram_rd_data;
      ram_rd_addr   = k_ff[ADDR_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in         = req_op;
               first_in      = req_first_name[NAME_BITS-1:0];
               last_in       = req_last_name[NAME_BITS-1:0];
               number_in     = req_phone_number[NAME_BITS-1:0];
               res_status_in = ST_OK;
               res_entry_in  = '0;
               state_in      = S_DONE;
               case (req_op) inside
                  OP_INSERT: begin
                     if (count_ff == COUNT_W'(CAPACITY)) begin
                        res_status_in = ST_FULL;
                     end else begin
                        k_in     = count_ff;
                        state_in = (count_ff == '0) ? S_INS_PUT : S_INS_RD;
                     end
                  end
                  OP_DELETE, OP_FIND: begin
                     k_in = '0;
                     if (count_ff == '0) begin
                        res_status_in = ST_NOT_FOUND;
                     end else begin
                        state_in = S_SCAN_RD;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_READ: begin
                     if (IDX_CMP_W'(req_entry_index) < IDX_CMP_W'(count_ff)) begin
                        k_in     = COUNT_W'(req_entry_index);
                        state_in = S_READ_RD;
                     end else begin
                        res_status_in = ST_BAD_INDEX;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_INS_RD: begin
            ram_rd_addr = k_dec[ADDR_W-1:0];
            state_in    = S_INS_CMP;
         end
         S_INS_CMP: begin
            ram_wr_en = 1'b1;
            if (first_ff < ram_rd_data.first) begin
               ram_wr_data = ram_rd_data;
               k_in        = k_dec;
               state_in    = (k_dec == '0) ? S_INS_PUT : S_INS_RD;
            end else begin
               ram_wr_data = new_entry;
               count_in    = count_ff + COUNT_W'(1);
               state_in    = S_DONE;
            end
         end
         S_INS_PUT: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = new_entry;
            count_in    = count_ff + COUNT_W'(1);
            state_in    = S_DONE;
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (hit) begin
               if (op_ff == OP_FIND) begin
                  res_entry_in = ram_rd_data;
                  state_in     = S_DONE;
               end else if (k_inc < count_ff) begin
                  state_in = S_SHIFT_RD;
               end else begin
                  count_in = count_ff - COUNT_W'(1);
                  state_in = S_DONE;
               end
            end else begin
               k_in = k_inc;
               if (k_inc < count_ff) begin
                  state_in = S_SCAN_RD;
               end else begin
                  res_status_in = ST_NOT_FOUND;
                  state_in      = S_DONE;
               end
            end
         end
         S_SHIFT_RD: begin
            ram_rd_addr = k_inc[ADDR_W-1:0];
            state_in    = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = ram_rd_data;
            k_in        = k_inc;
            if (k_inc2 < count_ff) begin
               state_in = S_SHIFT_RD;
            end else begin
               count_in = count_ff - COUNT_W'(1);
               state_in = S_DONE;
            end
         end
         S_READ_RD: begin
            state_in = S_READ_DATA;
         end
         S_READ_DATA: begin
            res_entry_in = ram_rd_data;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_first_in  = FIELD_W'(res_entry_ff.first);
               rsp_last_in   = FIELD_W'(res_entry_ff.last);
               rsp_number_in = FIELD_W'(res_entry_ff.number);
               rsp_count_in  = ENTRY_COUNT_W'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      op_ff         <= op_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      number_ff     <= number_in;
      res_status_ff <= res_status_in;
      res_entry_ff  <= res_entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_number_ff <= rsp_number_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found_first  = rsp_first_ff;
   assign rsp_found_last   = rsp_last_ff;
   assign rsp_found_number = rsp_number_ff;
   assign rsp_entry_count  = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == S_INS_CMP || state_ff == S_INS_PUT ||
                     state_ff == S_SHIFT_WR))
      else $error("entry RAM written outside insert or shift");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> (count_ff == $past(count_ff) + COUNT_W'(1) ||
                              count_ff == $past(count_ff) - COUNT_W'(1) ||
                              count_ff == '0))
      else $error("entry count moved by more than one");

   a_post_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished item not posted");

endmodule

`default_nettype wire

>>> rtl/core/srt_ram.sv
// ----------------------------------------------------------------------------
// srt_ram: generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module srt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: sorted name record table
// Drives insert, delete, find, clear, read and spare commands over the req_
// channel and checks every rsp_ item against a shadow of the table that is
// kept in step with each accepted command. Random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import srt_pkg::*;

   localparam int RANDOM_ITEMS = 1780;
   localparam int SEGMENT      = 150;
   localparam int QUIET_TAIL   = 150;
   localparam int DRAIN_EVERY  = 300;
   localparam int FIRST_POOL   = 12;
   localparam int LAST_POOL    = 4;
   localparam int REPORT_LIMIT = 10;

   localparam logic [OP_W-1:0] OP_SPARE_LO = OP_W'(OP_READ + 1);
   localparam logic [OP_W-1:0] OP_SPARE_HI = '1;

   localparam logic [FIELD_W-1:0] NAME_MARY  = 64'h4D41_5259_0000_0000;
   localparam logic [FIELD_W-1:0] NAME_ADAMS = 64'h4144_414D_5300_0000;
   localparam logic [FIELD_W-1:0] NAME_BROWN = 64'h4252_4F57_4E00_0000;
   localparam logic [FIELD_W-1:0] ALL_ONES   = '1;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [FIELD_W-1:0]       first;
      logic [FIELD_W-1:0]       last;
      logic [FIELD_W-1:0]       number;
      logic [ENTRY_COUNT_W-1:0] count;
   } reply_type;

   class table_scoreboard;
      logic [NAME_BITS-1:0] first_tab [CAPACITY];
      logic [NAME_BITS-1:0] last_tab [CAPACITY];
      logic [NAME_BITS-1:0] number_tab [CAPACITY];
      int held;
      reply_type expected_replies [$];
      int mismatches;
      int checked;
      int op_seen [8];
      int status_seen [4];

      function new();
         held = 0;
         mismatches = 0;
         checked = 0;
         foreach (op_seen[i]) op_seen[i] = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function int locate(logic [NAME_BITS-1:0] fn, logic [NAME_BITS-1:0] ln);
         for (int p = 0; p < held; p++)
            if (first_tab[p] == fn && last_tab[p] == ln) return p;
         return -1;
      endfunction

      function void note_command(logic [OP_W-1:0] op, logic [FIELD_W-1:0] fn_in,
                                 logic [FIELD_W-1:0] ln_in, logic [FIELD_W-1:0] num_in,
                                 logic [INDEX_W-1:0] idx);
         logic [NAME_BITS-1:0] fn;
         logic [NAME_BITS-1:0] ln;
         logic [NAME_BITS-1:0] num;
         reply_type rep;
         int pos;
         int hit;
         fn = fn_in[NAME_BITS-1:0];
         ln = ln_in[NAME_BITS-1:0];
         num = num_in[NAME_BITS-1:0];
         rep = '0;
         rep.status = ST_OK;
         case (op)
            OP_INSERT: begin
               if (held >= CAPACITY) begin
                  rep.status = ST_FULL;
               end else begin
                  pos = held;
                  for (int p = 0; p < held; p++)
                     if (fn < first_tab[p]) begin
                        pos = p;
                        break;
                     end
                  for (int k = held; k > pos; k--) begin
                     first_tab[k] = first_tab[k-1];
                     last_tab[k] = last_tab[k-1];
                     number_tab[k] = number_tab[k-1];
                  end
                  first_tab[pos] = fn;
                  last_tab[pos] = ln;
                  number_tab[pos] = num;
                  held++;
               end
            end
            OP_DELETE: begin
               hit = locate(fn, ln);
               if (hit < 0) begin
                  rep.status = ST_NOT_FOUND;
               end else begin
                  for (int k = hit; k + 1 < held; k++) begin
                     first_tab[k] = first_tab[k+1];
                     last_tab[k] = last_tab[k+1];
                     number_tab[k] = number_tab[k+1];
                  end
                  held--;
               end
            end
            OP_FIND: begin
               hit = locate(fn, ln);
               if (hit < 0) begin
                  rep.status = ST_NOT_FOUND;
               end else begin
                  rep.first = FIELD_W'(first_tab[hit]);
                  rep.last = FIELD_W'(last_tab[hit]);
                  rep.number = FIELD_W'(number_tab[hit]);
               end
            end
            OP_CLEAR: begin
               held = 0;
            end
            OP_READ: begin
               if (int'(idx) >= held) begin
                  rep.status = ST_BAD_INDEX;
               end else begin
                  rep.first = FIELD_W'(first_tab[idx]);
                  rep.last = FIELD_W'(last_tab[idx]);
                  rep.number = FIELD_W'(number_tab[idx]);
               end
            end
            default: begin
            end
         endcase
         rep.count = ENTRY_COUNT_W'(held);
         op_seen[op]++;
         status_seen[rep.status]++;
         expected_replies.push_back(rep);
      endfunction

      function void check_reply(reply_type got);
         reply_type want;
         if (expected_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: reply with no command waiting: status %0d count %0d",
                        $realtime, got.status, got.count);
            return;
         end
         want = expected_replies.pop_front();
         checked++;
         if (got.status !== want.status || got.first !== want.first ||
             got.last !== want.last || got.number !== want.number ||
             got.count !== want.count) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("%0t: reply mismatch on item %0d", $realtime, checked);
               $display("   expected status %0d first %h last %h number %h count %0d",
                        want.status, want.first, want.last, want.number, want.count);
               $display("   actual   status %0d first %h last %h number %h count %0d",
                        got.status, got.first, got.last, got.number, got.count);
            end
         end
      endfunction

      function void close_out();
         if (expected_replies.size() != 0) begin
            $display("%0t: %0d replies never arrived", $realtime, expected_replies.size());
            mismatches += expected_replies.size();
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [OP_W-1:0]          req_op;
   logic [FIELD_W-1:0]       req_first_name;
   logic [FIELD_W-1:0]       req_last_name;
   logic [FIELD_W-1:0]       req_phone_number;
   logic [INDEX_W-1:0]       req_entry_index;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [STATUS_W-1:0]      rsp_status;
   logic [FIELD_W-1:0]       rsp_found_first;
   logic [FIELD_W-1:0]       rsp_found_last;
   logic [FIELD_W-1:0]       rsp_found_number;
   logic [ENTRY_COUNT_W-1:0] rsp_entry_count;

   table_scoreboard sb;
   logic calm;
   int stall_left;
   logic [FIELD_W-1:0] first_pool [FIRST_POOL];
   logic [FIELD_W-1:0] last_pool [LAST_POOL];

   sorted_name_record_table u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_first_name   (req_first_name),
      .req_last_name    (req_last_name),
      .req_phone_number (req_phone_number),
      .req_entry_index  (req_entry_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_found_first  (rsp_found_first),
      .rsp_found_last   (rsp_found_last),
      .rsp_found_number (rsp_found_number),
      .rsp_entry_count  (rsp_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #12ms;
      $display("testbench: FAIL");
      $finish;
   end

   initial begin
      rsp_stall = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_stall = 1'b1;
            stall_left = $urandom_range(0, 7);
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_reply({rsp_status, rsp_found_first, rsp_found_last,
                         rsp_found_number, rsp_entry_count});
   end

   function automatic logic [FIELD_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [FIELD_W-1:0] pick_first();
      if ($urandom_range(0, 9) < 7) return first_pool[$urandom_range(0, FIRST_POOL-1)];
      return rand64();
   endfunction

   function automatic logic [FIELD_W-1:0] pick_last();
      if ($urandom_range(0, 9) < 7) return last_pool[$urandom_range(0, LAST_POOL-1)];
      return rand64();
   endfunction

   task automatic send_command(input logic [OP_W-1:0] op, input logic [FIELD_W-1:0] fn,
                               input logic [FIELD_W-1:0] ln, input logic [FIELD_W-1:0] num,
                               input logic [INDEX_W-1:0] idx);
      req_valid = 1'b1;
      req_op = op;
      req_first_name = fn;
      req_last_name = ln;
      req_phone_number = num;
      req_entry_index = idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_command(op, fn, ln, num, idx);
      @(negedge clock);
   endtask

   task automatic sender_gap();
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain_replies();
      req_valid = 1'b0;
      while (sb.expected_replies.size() != 0) @(negedge clock);
   endtask

   task automatic send_random(input int kind);
      int r;
      int pick;
      int k;
      int w_ins;
      int w_del;
      int w_find;
      int w_read;
      int w_clear;
      logic [OP_W-1:0] op;
      logic [FIELD_W-1:0] fn;
      logic [FIELD_W-1:0] ln;
      logic [INDEX_W-1:0] idx;
      case (kind)
         0: begin w_ins = 70; w_del = 80; w_find = 90; w_read = 100; w_clear = 100; end
         1: begin w_ins = 35; w_del = 60; w_find = 80; w_read = 95;  w_clear = 98;  end
         default: begin w_ins = 20; w_del = 65; w_find = 80; w_read = 95; w_clear = 98; end
      endcase
      r = $urandom_range(0, 99);
      if (r < w_ins) op = OP_INSERT;
      else if (r < w_del) op = OP_DELETE;
      else if (r < w_find) op = OP_FIND;
      else if (r < w_read) op = OP_READ;
      else if (r < w_clear) op = OP_CLEAR;
      else op = OP_LOGIC_SPARE();
      fn = pick_first();
      ln = pick_last();
      idx = INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
      if ((op == OP_DELETE || op == OP_FIND) && sb.held > 0) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            k = $urandom_range(0, sb.held - 1);
            fn = FIELD_W'(sb.first_tab[k]);
            ln = FIELD_W'(sb.last_tab[k]);
         end
      end
      if (op == OP_READ && sb.held > 0 && $urandom_range(0, 9) < 8)
         idx = INDEX_W'($urandom_range(0, sb.held - 1));
      send_command(op, fn, ln, rand64(), idx);
   endtask

   function automatic logic [OP_W-1:0] OP_LOGIC_SPARE();
      return OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
   endfunction

   initial begin
      sb = new();
      calm = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_INSERT;
      req_first_name = '0;
      req_last_name = '0;
      req_phone_number = '0;
      req_entry_index = '0;
      foreach (first_pool[i])
         first_pool[i] = (i % 2 == 0) ? {$urandom, 32'h0} : rand64();
      foreach (last_pool[i])
         last_pool[i] = rand64();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      send_command(OP_READ, '0, '0, '0, '0);
      send_command(OP_FIND, NAME_MARY, NAME_ADAMS, '0, '0);
      send_command(OP_DELETE, NAME_MARY, NAME_ADAMS, '0, '0);
      send_command(OP_INSERT, NAME_MARY, NAME_ADAMS, ALL_ONES, '1);
      sender_gap();
      send_command(OP_INSERT, ALL_ONES, ALL_ONES, '0, '0);
      send_command(OP_INSERT, '0, '0, 64'h0123_4567_89AB_CDEF, '0);
      send_command(OP_INSERT, NAME_MARY, NAME_BROWN, 64'h3535_3531_3231_3200, '0);
      send_command(OP_INSERT, NAME_MARY, NAME_ADAMS, 64'h3939_3900_0000_0000, '0);
      sender_gap();
      send_command(OP_READ, ALL_ONES, ALL_ONES, ALL_ONES, 6'd0);
      send_command(OP_READ, '0, '0, '0, 6'd4);
      send_command(OP_READ, '0, '0, '0, 6'd5);
      send_command(OP_READ, '0, '0, '0, '1);
      send_command(OP_FIND, NAME_MARY, NAME_ADAMS, '0, '0);
      send_command(OP_DELETE, NAME_MARY, NAME_ADAMS, '0, '0);
      send_command(OP_FIND, NAME_MARY, NAME_ADAMS, '0, '0);
      send_command(OP_FIND, NAME_MARY, ALL_ONES, '0, '0);
      send_command(OP_DELETE, ALL_ONES, ALL_ONES, '0, '0);
      send_command(OP_READ, '0, '0, '0, 6'd1);
      for (int s = OP_SPARE_LO; s <= OP_SPARE_HI; s++)
         send_command(OP_W'(s), rand64(), rand64(), rand64(),
                      INDEX_W'($urandom_range(0, 63)));
      drain_replies();
      send_command(OP_CLEAR, ALL_ONES, ALL_ONES, ALL_ONES, '1);
      send_command(OP_READ, '0, '0, '0, 6'd0);
      send_command(OP_INSERT, rand64(), rand64(), rand64(), '0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         calm = ((i / SEGMENT) % 4 == 3) || (i >= RANDOM_ITEMS - QUIET_TAIL);
         if (i > 0 && i % DRAIN_EVERY == 0) drain_replies();
         send_random((i / SEGMENT) % 3);
         sender_gap();
      end
      req_valid = 1'b0;

      while (sb.expected_replies.size() != 0) @(posedge clock);
      repeat (2 * CAPACITY + 8) @(posedge clock);
      sb.close_out();

      $display("summary: %0d replies checked; %0d insert, %0d delete, %0d find,",
               sb.checked, sb.op_seen[OP_INSERT], sb.op_seen[OP_DELETE],
               sb.op_seen[OP_FIND]);
      $display("summary: %0d clear, %0d read; status ok %0d, not found %0d,",
               sb.op_seen[OP_CLEAR], sb.op_seen[OP_READ], sb.status_seen[ST_OK],
               sb.status_seen[ST_NOT_FOUND]);
      $display("summary: table full %0d, bad index %0d",
               sb.status_seen[ST_FULL], sb.status_seen[ST_BAD_INDEX]);
      if (sb.mismatches == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/srt_pkg.sv
rtl/core/srt_ram.sv
rtl/core/sorted_name_record_table.sv
dv/testbench.sv
